[rtl/nchit_pkg.sv]
// Shared types, constants and codes for the nearest cluster hit assignment unit.
package nchit_pkg;

    localparam int MAX_HITS     = 1024;
    localparam int MAX_CLUSTERS = 64;

    localparam int HIT_AW   = $clog2(MAX_HITS);
    localparam int CNT_W    = HIT_AW + 1;
    localparam int CL_AW    = $clog2(MAX_CLUSTERS);
    localparam int ID_W     = 6;
    localparam int LAYER_W  = 12;
    localparam int POS_W    = 16;
    localparam int ENERGY_W = 16;
    localparam int DIST_W   = 2 * (POS_W + 1);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_NONE    = 2'd2;

    localparam logic CFG_MAX_DIST  = 1'b0;
    localparam logic CFG_LAYER_WIN = 1'b1;

    localparam logic [DIST_W-1:0]  MAX_DIST_RST  = DIST_W'(6400);
    localparam logic [LAYER_W-1:0] LAYER_WIN_RST = LAYER_W'(10);

    typedef struct packed {
        logic [1:0]                func;
        logic [ID_W-1:0]           cluster_id;
        logic [LAYER_W-1:0]        layer;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic [ENERGY_W-1:0]       cluster_energy;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [ID_W-1:0]           best_cluster;
        logic [DIST_W-1:0]         best_distance_sq;
        logic [ENERGY_W-1:0]       best_energy;
    } res_t;

    typedef struct packed {
        logic [ID_W-1:0]           cluster_id;
        logic [LAYER_W-1:0]        layer;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
    } hit_t;

    typedef struct packed {
        logic valid;
        logic first;
    } dist_ctl_t;

    typedef struct packed {
        logic               e_we;
        logic               m_we;
        logic               rd;
        logic               v_clear;
        logic [CL_AW-1:0]   waddr;
        logic [CL_AW-1:0]   raddr;
    } ctab_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FX,
        S_FY,
        S_FZ,
        S_WAIT,
        S_UPD,
        S_CRD,
        S_CCMP
    } state_t;

endpackage

[rtl/nearest_cluster_hit_assign_unit.sv]
// Clear and load: result in the cycle after acceptance, busy stays low, one item per cycle.
// Query: every stored hit in the layer window runs through the shared squared distance unit
// (S_FX, S_FY, S_FZ, S_WAIT, S_UPD), a hit outside the window is skipped in S_FX; then every
// cluster in the cluster table is read and compared (S_CRD, S_CCMP) before the result.
// Reset empties the hit store and loads the register defaults; results cannot be stalled.
module nearest_cluster_hit_assign_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nchit_pkg::cmd_t               cmd,
    output logic                          done,
    output nchit_pkg::res_t               result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [nchit_pkg::DIST_W-1:0]  cfg_data
);
    import nchit_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     hit_count_reg, hit_count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CL_AW-1:0]     cl_reg, cl_next;
    cmd_t                 q_reg, q_next;
    logic [DIST_W-1:0]    cur_d_reg, cur_d_next;
    logic [ENERGY_W-1:0]  cur_e_reg, cur_e_next;
    logic [ID_W-1:0]      best_id_reg, best_id_next;
    logic                 found_reg, found_next;
    res_t                 res_reg, res_next;
    logic                 done_reg, done_next;
    logic [DIST_W-1:0]    max_dist_reg;
    logic [LAYER_W-1:0]   layer_win_reg;

    logic                 hs_we;
    logic                 hs_re;
    logic [HIT_AW-1:0]    hs_raddr;
    hit_t                 hit_rd;
    hit_t                 hit_wr;

    dist_ctl_t            dctl;
    logic signed [POS_W-1:0] da, db;
    logic [DIST_W-1:0]    acc;

    ctab_req_t            creq;
    logic [ENERGY_W-1:0]  e_rdata;
    logic [DIST_W-1:0]    m_rdata;
    logic                 m_valid;

    logic                 accept;
    logic                 load_drop;
    logic [CNT_W-1:0]     idx_inc;
    logic                 last_hit;
    logic [LAYER_W:0]     ldiff;
    logic [LAYER_W:0]     labs;
    logic                 in_win;
    logic                 cl_better;

    assign accept    = start && !busy;
    assign load_drop = (hit_count_reg >= CNT_W'(MAX_HITS))
                       || (32'(cmd.cluster_id) >= MAX_CLUSTERS);
    assign idx_inc   = idx_reg + 1'b1;
    assign last_hit  = (idx_inc == hit_count_reg);
    assign ldiff     = {1'b0, hit_rd.layer} - {1'b0, q_reg.layer};
    assign labs      = ldiff[LAYER_W] ? -ldiff : ldiff;
    assign in_win    = labs <= {1'b0, layer_win_reg};
    // strict compare keeps the lower id on a full tie
    assign cl_better = m_valid && ((m_rdata < cur_d_reg)
                       || ((m_rdata == cur_d_reg) && (e_rdata > cur_e_reg)));

    assign hit_wr.cluster_id = cmd.cluster_id;
    assign hit_wr.layer      = cmd.layer;
    assign hit_wr.pos_x      = cmd.pos_x;
    assign hit_wr.pos_y      = cmd.pos_y;
    assign hit_wr.pos_z      = cmd.pos_z;

    nchit_hit_store u_hit_store (
        .clk   (clk),
        .we    (hs_we),
        .waddr (hit_count_reg[HIT_AW-1:0]),
        .wdata (hit_wr),
        .re    (hs_re),
        .raddr (hs_raddr),
        .rdata (hit_rd)
    );

    nchit_dist_unit u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .a     (da),
        .b     (db),
        .acc   (acc)
    );

    nchit_cluster_table u_ctab (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (creq),
        .e_wdata (cmd.cluster_energy),
        .m_wdata (acc),
        .e_rdata (e_rdata),
        .m_rdata (m_rdata),
        .m_valid (m_valid)
    );

    always_comb
    begin
        state_next     = state_reg;
        hit_count_next = hit_count_reg;
        idx_next       = idx_reg;
        cl_next        = cl_reg;
        q_next         = q_reg;
        cur_d_next     = cur_d_reg;
        cur_e_next     = cur_e_reg;
        best_id_next   = best_id_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        done_next      = 1'b0;
        hs_we          = 1'b0;
        hs_re          = 1'b0;
        hs_raddr       = idx_inc[HIT_AW-1:0];
        dctl           = '0;
        da             = hit_rd.pos_x;
        db             = q_reg.pos_x;
        creq           = '0;
        creq.waddr     = hit_rd.cluster_id[CL_AW-1:0];
        creq.raddr     = hit_rd.cluster_id[CL_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next  = '0;
                    done_next = 1'b1;
                    case (cmd.func)
                        FUNC_CLEAR:
                        begin
                            hit_count_next = '0;
                        end
                        FUNC_LOAD:
                        begin
                            if (load_drop)
                            begin
                                res_next.status = STATUS_DROPPED;
                            end
                            else
                            begin
                                hs_we          = 1'b1;
                                creq.e_we      = 1'b1;
                                creq.waddr     = cmd.cluster_id[CL_AW-1:0];
                                hit_count_next = hit_count_reg + 1'b1;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            done_next    = 1'b0;
                            q_next       = cmd;
                            creq.v_clear = 1'b1;
                            cur_d_next   = max_dist_reg;
                            cur_e_next   = '0;
                            best_id_next = '0;
                            found_next   = 1'b0;
                            idx_next     = '0;
                            cl_next      = '0;
                            if (hit_count_reg == '0)
                            begin
                                state_next = S_CRD;
                            end
                            else
                            begin
                                hs_re      = 1'b1;
                                hs_raddr   = '0;
                                state_next = S_FX;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_FX:
            begin
                if (in_win)
                begin
                    dctl.valid = 1'b1;
                    dctl.first = 1'b1;
                    creq.rd    = 1'b1;
                    state_next = S_FY;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (last_hit)
                    begin
                        state_next = S_CRD;
                    end
                    else
                    begin
                        hs_re = 1'b1;
                    end
                end
            end
            S_FY:
            begin
                dctl.valid = 1'b1;
                da         = hit_rd.pos_y;
                db         = q_reg.pos_y;
                state_next = S_FZ;
            end
            S_FZ:
            begin
                dctl.valid = 1'b1;
                da         = hit_rd.pos_z;
                db         = q_reg.pos_z;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!m_valid || (acc < m_rdata))
                begin
                    creq.m_we = 1'b1;
                end
                idx_next = idx_inc;
                if (last_hit)
                begin
                    state_next = S_CRD;
                end
                else
                begin
                    hs_re      = 1'b1;
                    state_next = S_FX;
                end
            end
            S_CRD:
            begin
                creq.rd    = 1'b1;
                creq.raddr = cl_reg;
                state_next = S_CCMP;
            end
            S_CCMP:
            begin
                if (cl_better)
                begin
                    cur_d_next   = m_rdata;
                    cur_e_next   = e_rdata;
                    best_id_next = ID_W'(cl_reg);
                    found_next   = 1'b1;
                end
                if (cl_reg == CL_AW'(MAX_CLUSTERS - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = '0;
                    if (found_next)
                    begin
                        res_next.status           = STATUS_OK;
                        res_next.best_cluster     = best_id_next;
                        res_next.best_distance_sq = cur_d_next;
                        res_next.best_energy      = cur_e_next;
                    end
                    else
                    begin
                        res_next.status = STATUS_NONE;
                    end
                end
                else
                begin
                    cl_next    = cl_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hit_count_reg <= '0;
            idx_reg       <= '0;
            cl_reg        <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_count_reg <= hit_count_next;
            idx_reg       <= idx_next;
            cl_reg        <= cl_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        cur_d_reg   <= cur_d_next;
        cur_e_reg   <= cur_e_next;
        best_id_reg <= best_id_next;
        found_reg   <= found_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg  <= MAX_DIST_RST;
            layer_win_reg <= LAYER_WIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_DIST:  max_dist_reg  <= cfg_data;
                CFG_LAYER_WIN: layer_win_reg <= cfg_data[LAYER_W-1:0];
                default:       max_dist_reg  <= max_dist_reg;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // every accepted item gives a result next cycle or starts a query walk
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted item neither answered nor in progress");

    // end of a query walk delivers its result
    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without result");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.func == FUNC_LOAD) && !load_drop)
        |=> (hit_count_reg == $past(hit_count_reg) + 1'b1))
        else $error("stored load did not advance hit count");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STATUS_NONE))
        |-> ((result.best_cluster == '0) && (result.best_distance_sq == '0)
             && (result.best_energy == '0)))
        else $error("no-cluster result carries data");

endmodule

[rtl/nchit_hit_store.sv]
// Hit store: one write port, one registered read port.
module nchit_hit_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [nchit_pkg::HIT_AW-1:0]  waddr,
    input  nchit_pkg::hit_t               wdata,
    input  logic                          re,
    input  logic [nchit_pkg::HIT_AW-1:0]  raddr,
    output nchit_pkg::hit_t               rdata
);
    import nchit_pkg::*;

    hit_t mem [MAX_HITS];
    hit_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nchit_dist_unit.sv]
// Shared squared distance unit: pre-subtract, square, accumulate.
module nchit_dist_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nchit_pkg::dist_ctl_t                 ctl,
    input  logic signed [nchit_pkg::POS_W-1:0]   a,
    input  logic signed [nchit_pkg::POS_W-1:0]   b,
    output logic [nchit_pkg::DIST_W-1:0]         acc
);
    import nchit_pkg::*;

    logic signed [POS_W:0]    diff;
    logic signed [DIST_W-1:0] prod;
    logic [DIST_W-1:0]        sq_reg;
    logic [DIST_W-1:0]        acc_reg;
    logic                     sq_vld_reg;
    logic                     sq_first_reg;

    assign diff = (POS_W + 1)'(a) - (POS_W + 1)'(b);
    assign prod = diff * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg   <= 1'b0;
            sq_first_reg <= 1'b0;
        end
        else
        begin
            sq_vld_reg   <= ctl.valid;
            sq_first_reg <= ctl.first;
        end
    end

    // sum of three squares stays below 2^34, no overflow
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            sq_reg <= unsigned'(prod);
        end
        if (sq_vld_reg)
        begin
            acc_reg <= sq_first_reg ? sq_reg : acc_reg + sq_reg;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/nchit_cluster_table.sv]
// Per-cluster energy and least distance memories with per-query valid bits.
module nchit_cluster_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  nchit_pkg::ctab_req_t            req,
    input  logic [nchit_pkg::ENERGY_W-1:0]  e_wdata,
    input  logic [nchit_pkg::DIST_W-1:0]    m_wdata,
    output logic [nchit_pkg::ENERGY_W-1:0]  e_rdata,
    output logic [nchit_pkg::DIST_W-1:0]    m_rdata,
    output logic                            m_valid
);
    import nchit_pkg::*;

    logic [ENERGY_W-1:0]     energy_mem [MAX_CLUSTERS];
    logic [DIST_W-1:0]       min_mem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] valid_reg;
    logic [MAX_CLUSTERS-1:0] valid_next;
    logic                    m_valid_reg;
    logic [ENERGY_W-1:0]     e_rdata_reg;
    logic [DIST_W-1:0]       m_rdata_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.v_clear)
        begin
            valid_next = '0;
        end
        if (req.m_we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd)
            begin
                m_valid_reg <= valid_reg[req.raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.e_we)
        begin
            energy_mem[req.waddr] <= e_wdata;
        end
        if (req.m_we)
        begin
            min_mem[req.waddr] <= m_wdata;
        end
        if (req.rd)
        begin
            e_rdata_reg <= energy_mem[req.raddr];
            m_rdata_reg <= min_mem[req.raddr];
        end
    end

    assign e_rdata = e_rdata_reg;
    assign m_rdata = m_rdata_reg;
    assign m_valid = m_valid_reg;

endmodule
